### design/pgpf_pkg.sv
// Shared constants, register indexes and payload types for the profile gap
// pattern finder. No dependencies; every design file imports this package.
package pgpf_pkg;

  localparam int MAX_SAMPLES    = 2048;
  localparam int AW             = $clog2(MAX_SAMPLES);
  localparam int CW             = AW + 1;
  localparam int PATTERN_POINTS = 6;
  localparam int PW             = $clog2(PATTERN_POINTS + 1);
  localparam int PIW            = (PATTERN_POINTS > 1) ? $clog2(PATTERN_POINTS) : 1;
  localparam int POSW           = ((AW + 1 > 16) ? AW + 1 : 16) + 1;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 48;

  // register indexes on the configuration port
  localparam logic [CFG_IW-1:0] REG_POINT_ONE        = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SEARCH_MODE      = 3'd6;
  localparam logic [CFG_IW-1:0] REG_POSITION_OFFSETS = 3'd7;

  typedef struct packed {
    logic signed [15:0] height;
    logic               in_range;
    logic               line_bad;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] gap_x;
    logic signed [15:0] gap_y;
    logic               found;
  } out_item_t;

  typedef struct packed {
    logic [PATTERN_POINTS-1:0][47:0] points;
    logic [3:0]                      mode;
    logic [47:0]                     offsets;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [AW-1:0]     waddr;
    logic [15:0]       wdata;
    logic [AW-1:0]     raddr;
  } mem_req_t;

endpackage

### design/pgpf_store.sv
// Profile sample memory: one write port, one read port with registered data.
// Depends on pgpf_pkg for the depth and the request struct.
module pgpf_store import pgpf_pkg::*; (
  input  logic        clk,
  input  mem_req_t    req,
  output logic [15:0] rdata
);

  logic [15:0] mem [MAX_SAMPLES];
  logic [15:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

### design/pgpf_point_unit.sv
// Shared compare unit: position of a pattern point relative to a start index
// with its range check, and the height step check against two limits.
// Depends on pgpf_pkg for widths.
module pgpf_point_unit import pgpf_pkg::*; (
  input  logic [AW-1:0]      start_idx,
  input  logic signed [15:0] offset,
  input  logic [AW-1:0]      first_valid,
  input  logic [AW-1:0]      last_valid,
  input  logic signed [15:0] h0,
  input  logic signed [15:0] h2,
  input  logic signed [15:0] lim_a,
  input  logic signed [15:0] lim_b,
  output logic               pos_ok,
  output logic [AW-1:0]      pos_addr,
  output logic               step_ok
);

  logic signed [POSW-1:0] pos;
  logic signed [POSW-1:0] fv_s;
  logic signed [POSW-1:0] lv_s;
  logic signed [16:0]     step;
  logic signed [16:0]     lo;
  logic signed [16:0]     hi;

  always_comb begin
    pos  = POSW'($signed({1'b0, start_idx})) + POSW'(offset);
    fv_s = POSW'($signed({1'b0, first_valid}));
    lv_s = POSW'($signed({1'b0, last_valid}));
    pos_ok   = (pos >= fv_s) && (pos <= lv_s);
    pos_addr = pos[AW-1:0];

    step = 17'(h2) - 17'(h0);
    // limits may come in either order
    if (lim_a < lim_b) begin
      lo = 17'(lim_a);
      hi = 17'(lim_b);
    end else begin
      lo = 17'(lim_b);
      hi = 17'(lim_a);
    end
    step_ok = !h2[15] && (step >= lo) && (step <= hi);
  end

endmodule

### design/pgpf_scan.sv
// Load and scan sequencer: stores samples, tracks the valid window, walks every
// start index through the shared point unit and forms the result.
// Depends on pgpf_pkg and pgpf_point_unit.
module pgpf_scan import pgpf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_item_t    in_item,
  input  cfg_t        cfg,
  input  logic [15:0] rdata,
  output mem_req_t    mem_req,
  output logic        busy,
  output logic        out_valid,
  output out_item_t   out_item
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEXT = 3'd1;
  localparam logic [2:0] ST_H0   = 3'd2;
  localparam logic [2:0] ST_PT   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]         st_r, st_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [AW-1:0]      fv_r, fv_nxt;
  logic [AW-1:0]      lv_r, lv_nxt;
  logic               seen_r, seen_nxt;
  logic [AW-1:0]      s_r, s_nxt;
  logic [PW-1:0]      p_r, p_nxt;
  logic [PW-1:0]      npts_r, npts_nxt;
  logic signed [15:0] h0_r, h0_nxt;
  logic               match_r, match_nxt;
  logic [15:0]        mx_r, mx_nxt;
  logic [15:0]        my_r, my_nxt;
  logic signed [15:0] prev_x_r, prev_x_nxt;
  logic signed [15:0] prev_y_r, prev_y_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [PW-1:0]      pidx_pos;
  logic [47:0]        pt_pos;
  logic [47:0]        pt_step;
  logic               pos_ok;
  logic [AW-1:0]      pos_addr;
  logic               step_ok;
  logic signed [15:0] h0_sel;
  logic [PW-1:0]      npts_req;
  logic signed [15:0] res_x;
  logic signed [15:0] res_y;

  // (m*256 + o)/256 truncated toward zero, saturated to 16 signed bits
  function automatic logic signed [15:0] place(input logic [15:0] m,
                                               input logic [23:0] o);
    logic signed [25:0] v;
    logic signed [17:0] q;
    v = $signed({2'b00, m, 8'h00}) + 26'($signed(o));
    q = v[25:8];
    if (v[25] && (v[7:0] != 8'h00)) begin
      q = q + 18'sd1;
    end
    if (q > 18'sd32767) begin
      return 16'sh7fff;
    end else if (q < -18'sd32768) begin
      return 16'sh8000;
    end
    return q[15:0];
  endfunction

  always_comb begin
    pidx_pos = (st_r == ST_PT) ? p_r + PW'(1) : '0;
    pt_pos   = (pidx_pos < PW'(PATTERN_POINTS)) ? cfg.points[pidx_pos[PIW-1:0]] : '0;
    pt_step  = (p_r < PW'(PATTERN_POINTS)) ? cfg.points[p_r[PIW-1:0]] : '0;
    h0_sel   = (st_r == ST_PT) ? h0_r : $signed(rdata);
    npts_req = (cfg.mode[3:1] > 3'(PATTERN_POINTS)) ? PW'(PATTERN_POINTS)
                                                    : PW'(cfg.mode[3:1]);
    res_x    = place(mx_r, cfg.offsets[23:0]);
    res_y    = place(my_r, cfg.offsets[47:24]);
  end

  pgpf_point_unit u_point (
    .start_idx   (s_r),
    .offset      ($signed(pt_pos[15:0])),
    .first_valid (fv_r),
    .last_valid  (lv_r),
    .h0          (h0_sel),
    .h2          ($signed(rdata)),
    .lim_a       ($signed(pt_step[31:16])),
    .lim_b       ($signed(pt_step[47:32])),
    .pos_ok      (pos_ok),
    .pos_addr    (pos_addr),
    .step_ok     (step_ok)
  );

  always_comb begin
    st_nxt        = st_r;
    cnt_nxt       = cnt_r;
    fv_nxt        = fv_r;
    lv_nxt        = lv_r;
    seen_nxt      = seen_r;
    s_nxt         = s_r;
    p_nxt         = p_r;
    npts_nxt      = npts_r;
    h0_nxt        = h0_r;
    match_nxt     = match_r;
    mx_nxt        = mx_r;
    my_nxt        = my_r;
    prev_x_nxt    = prev_x_r;
    prev_y_nxt    = prev_y_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = cnt_r[AW-1:0];
    mem_req.wdata = in_item.height;
    mem_req.raddr = s_r;

    case (st_r)
      ST_IDLE: begin
        if (start) begin
          if (cnt_r < CW'(MAX_SAMPLES)) begin
            mem_req.we = 1'b1;
            cnt_nxt    = cnt_r + CW'(1);
            if (in_item.in_range) begin
              if (!seen_r) begin
                fv_nxt = cnt_r[AW-1:0];
              end
              lv_nxt   = cnt_r[AW-1:0];
              seen_nxt = 1'b1;
            end
          end
          if (in_item.last_sample) begin
            cnt_nxt = '0;
            if (in_item.line_bad) begin
              // repeat the previous position, drop the profile
              out_valid_nxt      = 1'b1;
              out_item_nxt.gap_x = prev_x_r;
              out_item_nxt.gap_y = prev_y_r;
              out_item_nxt.found = 1'b0;
              fv_nxt    = '0;
              lv_nxt    = '0;
              seen_nxt  = 1'b0;
              match_nxt = 1'b0;
            end else begin
              npts_nxt = npts_req;
              s_nxt    = fv_nxt;
              st_nxt   = ST_NEXT;
            end
          end
        end
      end
      ST_NEXT: begin
        if (s_r < lv_r) begin
          mem_req.raddr = s_r;
          st_nxt        = ST_H0;
        end else begin
          st_nxt = ST_FIN;
        end
      end
      ST_H0: begin
        h0_nxt = $signed(rdata);
        st_nxt = ST_NEXT;
        s_nxt  = s_r + AW'(1);
        if (rdata[15]) begin
          // negative start height: advance
        end else if (npts_r == '0) begin
          match_nxt = 1'b1;
          if (!match_r || !cfg.mode[0]) begin
            mx_nxt = 16'(s_r);
            my_nxt = rdata;
          end
        end else if (pos_ok) begin
          mem_req.raddr = pos_addr;
          p_nxt         = '0;
          s_nxt         = s_r;
          st_nxt        = ST_PT;
        end
      end
      ST_PT: begin
        st_nxt = ST_NEXT;
        s_nxt  = s_r + AW'(1);
        if (!step_ok) begin
          // point failed: advance to the next start
        end else if (p_r + PW'(1) == npts_r) begin
          match_nxt = 1'b1;
          if (!match_r || !cfg.mode[0]) begin
            mx_nxt = 16'(s_r);
            my_nxt = h0_r;
          end
        end else if (pos_ok) begin
          mem_req.raddr = pos_addr;
          p_nxt         = p_r + PW'(1);
          s_nxt         = s_r;
          st_nxt        = ST_PT;
        end
      end
      ST_FIN: begin
        out_valid_nxt = 1'b1;
        if (match_r) begin
          out_item_nxt.gap_x = res_x;
          out_item_nxt.gap_y = res_y;
          out_item_nxt.found = 1'b1;
          prev_x_nxt         = res_x;
          prev_y_nxt         = res_y;
        end else begin
          out_item_nxt.gap_x = '0;
          out_item_nxt.gap_y = '0;
          out_item_nxt.found = 1'b0;
          prev_x_nxt         = '0;
          prev_y_nxt         = '0;
        end
        fv_nxt    = '0;
        lv_nxt    = '0;
        seen_nxt  = 1'b0;
        match_nxt = 1'b0;
        st_nxt    = ST_IDLE;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      cnt_r       <= '0;
      fv_r        <= '0;
      lv_r        <= '0;
      seen_r      <= 1'b0;
      match_r     <= 1'b0;
      mx_r        <= '0;
      my_r        <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_r       <= cnt_nxt;
      fv_r        <= fv_nxt;
      lv_r        <= lv_nxt;
      seen_r      <= seen_nxt;
      match_r     <= match_nxt;
      mx_r        <= mx_nxt;
      my_r        <= my_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r        <= s_nxt;
    p_r        <= p_nxt;
    npts_r     <= npts_nxt;
    h0_r       <= h0_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (st_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### design/profile_gap_pattern_finder_unit.sv
// Profile gap pattern finder. Samples load one per cycle while busy is low; the last
// sample of a bad line gives its result in the next cycle. Otherwise the scan runs
// after the last sample and walks the start indexes one at a time through the
// single memory read port and the one shared point unit; no new sample is taken
// until it ends. busy is high during the scan. The receiver cannot stall.
// Synchronous reset clears configuration, counters and the previous position;
// the sample memory is not cleared.
module profile_gap_pattern_finder_unit import pgpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_idx,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  cfg_t        cfg_r;
  mem_req_t    mem_req;
  logic [15:0] rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      for (int i = 0; i < PATTERN_POINTS; i++) begin
        if (cfg_idx == REG_POINT_ONE + CFG_IW'(i)) begin
          cfg_r.points[i] <= cfg_wdata;
        end
      end
      if (cfg_idx == REG_SEARCH_MODE) begin
        cfg_r.mode <= cfg_wdata[3:0];
      end
      if (cfg_idx == REG_POSITION_OFFSETS) begin
        cfg_r.offsets <= cfg_wdata;
      end
    end
  end

  pgpf_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  pgpf_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .cfg       (cfg_r),
    .rdata     (rdata),
    .mem_req   (mem_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### tb/sv/tb_profile_gap_pattern_finder_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for profile_gap_pattern_finder_unit: loads height profiles,
// predicts each gap result in place and checks it field by field.
// Depends on pgpf_pkg and the design top module.
module tb_profile_gap_pattern_finder_unit;
  import pgpf_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        reconfig;
    bit        known;
    out_item_t result;
  } directed_row_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  in_item_t          in_item;
  logic              out_valid;
  out_item_t         out_item;
  logic              cfg_we;
  logic [CFG_IW-1:0] cfg_idx;
  logic [CFG_DW-1:0] cfg_wdata;

  // predicted block state
  cfg_t               gap_cfg;
  shortint            profile_heights [MAX_SAMPLES];
  int                 sample_count;
  int                 first_valid;
  int                 last_valid;
  bit                 seen_valid;
  logic signed [15:0] prev_x;
  logic signed [15:0] prev_y;

  out_item_t expected_gaps [$];
  int        mismatch_count;
  int        results_checked;
  int        gaps_found;
  int        samples_sent;
  int        profiles_sent;
  int        settings_used;
  int        idle_pct;

  profile_gap_pattern_finder_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #10ms;
    $display("timeout: gap results still outstanding");
    $display("Mismatches found");
    $finish;
  end

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // true when start index s passes the height check and every active point
  function automatic bit start_fits(int s, int npts);
    int      h0;
    int      h2;
    int      pos;
    int      rise;
    shortint off;
    shortint lim_a;
    shortint lim_b;
    h0 = profile_heights[s];
    if (h0 < 0) return 1'b0;
    for (int p = 0; p < npts; p++) begin
      off   = gap_cfg.points[p][15:0];
      lim_a = gap_cfg.points[p][31:16];
      lim_b = gap_cfg.points[p][47:32];
      pos   = s + off;
      if (pos < first_valid || pos > last_valid) return 1'b0;
      h2 = profile_heights[pos];
      if (h2 < 0) return 1'b0;
      rise = h2 - h0;
      if (lim_a < lim_b) begin
        if (rise < lim_a || rise > lim_b) return 1'b0;
      end else begin
        if (rise < lim_b || rise > lim_a) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // store one sample; on the final sample scan the profile and form the gap
  function automatic void take_sample(input in_item_t it, output bit has_result,
                                      output out_item_t gap);
    int                 npts;
    int                 first_s;
    int                 last_s;
    int                 mx;
    int                 my;
    bit                 matched;
    logic signed [23:0] off_x;
    logic signed [23:0] off_y;
    longint             ox;
    longint             oy;
    has_result = 1'b0;
    gap        = '0;
    if (sample_count < MAX_SAMPLES) begin
      profile_heights[sample_count] = it.height;
      if (it.in_range) begin
        if (!seen_valid) first_valid = sample_count;
        last_valid = sample_count;
        seen_valid = 1'b1;
      end
      sample_count++;
    end
    if (!it.last_sample) return;
    has_result = 1'b1;
    if (it.line_bad) begin
      gap.gap_x = prev_x;
      gap.gap_y = prev_y;
    end else begin
      npts = gap_cfg.mode[3:1];
      if (npts > PATTERN_POINTS) npts = PATTERN_POINTS;
      matched = 1'b0;
      first_s = 0;
      last_s  = 0;
      if (seen_valid) begin
        for (int s = first_valid; s < last_valid; s++) begin
          if (start_fits(s, npts)) begin
            if (!matched) first_s = s;
            matched = 1'b1;
            last_s  = s;
          end
        end
      end
      if (matched) begin
        mx    = gap_cfg.mode[0] ? first_s : last_s;
        my    = profile_heights[mx];
        off_x = gap_cfg.offsets[23:0];
        off_y = gap_cfg.offsets[47:24];
        ox    = off_x;
        oy    = off_y;
        gap.gap_x = clamp16((longint'(mx) * 256 + ox) / 256);
        gap.gap_y = clamp16((longint'(my) * 256 + oy) / 256);
        gap.found = 1'b1;
      end
      prev_x = gap.gap_x;
      prev_y = gap.gap_y;
    end
    sample_count = 0;
    first_valid  = 0;
    last_valid   = 0;
    seen_valid   = 1'b0;
  endfunction

  function automatic directed_row_t mk(int h, bit rng, bit bad, bit fin, bit reconfig,
                                       bit known = 1'b0, int gx = 0, int gy = 0,
                                       bit fnd = 1'b0);
    directed_row_t r;
    r.item.height      = 16'(h);
    r.item.in_range    = rng;
    r.item.line_bad    = bad;
    r.item.last_sample = fin;
    r.reconfig         = reconfig;
    r.known            = known;
    r.result.gap_x     = 16'(gx);
    r.result.gap_y     = 16'(gy);
    r.result.found     = fnd;
    return r;
  endfunction

  function automatic cfg_t random_cfg(int phase);
    cfg_t        c;
    logic [15:0] off;
    logic [15:0] lim_a;
    logic [15:0] lim_b;
    logic [23:0] ox;
    logic [23:0] oy;
    if (phase == 0) return '1;
    if (phase == 1) return '0;
    for (int p = 0; p < PATTERN_POINTS; p++) begin
      off   = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 8) - 4) : 16'($urandom());
      lim_a = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 60) - 30) : 16'($urandom());
      lim_b = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 60) - 30) : 16'($urandom());
      c.points[p] = {lim_b, lim_a, off};
    end
    ox = ($urandom_range(0, 2) != 0) ? 24'($urandom_range(0, 4096) - 2048) : 24'($urandom());
    oy = ($urandom_range(0, 2) != 0) ? 24'($urandom_range(0, 4096) - 2048) : 24'($urandom());
    c.mode    = 4'($urandom_range(0, 15));
    c.offsets = {oy, ox};
    return c;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic send_item(in_item_t it, bit known, out_item_t typed);
    bit        has_result;
    out_item_t gap;
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 16));
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    take_sample(it, has_result, gap);
    samples_sent++;
    if (has_result) begin
      profiles_sent++;
      expected_gaps.insert(expected_gaps.size(), known ? typed : gap);
    end
  endtask

  // hold off requests until every pending gap result is back and the scan has ended
  task automatic drain();
    int waited;
    waited = 0;
    idle_cycles(1);
    while (expected_gaps.size() != 0 && waited < 30000) begin
      @(negedge clk);
      waited++;
    end
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
  endtask

  task automatic apply_config(cfg_t c);
    logic [CFG_DW-1:0] mode_word;
    // upper bits of the mode word are don't-care; fill them with noise
    mode_word      = {$urandom(), 16'($urandom())};
    mode_word[3:0] = c.mode;
    for (int p = 0; p < PATTERN_POINTS; p++)
      write_reg(REG_POINT_ONE + CFG_IW'(p), c.points[p]);
    write_reg(REG_SEARCH_MODE, mode_word);
    write_reg(REG_POSITION_OFFSETS, c.offsets);
    @(negedge clk);
    cfg_we  <= 1'b0;
    gap_cfg  = c;
    settings_used++;
  endtask

  task automatic send_profile(int len, bit long_run);
    in_item_t it;
    int       kind;
    int       win_lo;
    int       win_hi;
    int       pick;
    int       h;
    kind   = long_run ? 2 : $urandom_range(0, 9);
    win_lo = long_run ? MAX_SAMPLES - 8 : $urandom_range(0, len - 1);
    win_hi = long_run ? len - 1 : $urandom_range(win_lo, len - 1);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (kind == 0 || pick >= 18) begin
        it.height = 16'($urandom());
      end else if (pick >= 15) begin
        h = $urandom_range(1, 40);
        it.height = 16'(-h);
      end else begin
        it.height = 16'($urandom_range(0, 40));
      end
      if (kind == 0) it.in_range = 1'($urandom());
      else if (kind == 1) it.in_range = 1'b0;
      else if (i >= win_lo && i <= win_hi) it.in_range = ($urandom_range(0, 9) != 0);
      else it.in_range = ($urandom_range(0, 9) == 0);
      it.last_sample = (i == len - 1);
      it.line_bad    = it.last_sample ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 7) == 0);
      send_item(it, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_gaps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected gap result: x=%0d y=%0d found=%0b",
                   out_item.gap_x, out_item.gap_y, out_item.found);
      end else begin
        want = expected_gaps.pop_front();
        results_checked++;
        if (want.found) gaps_found++;
        if (out_item.gap_x !== want.gap_x || out_item.gap_y !== want.gap_y ||
            out_item.found !== want.found) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result %0d: want x=%0d y=%0d found=%0b, got x=%0d y=%0d found=%0b",
                     results_checked, want.gap_x, want.gap_y, want.found,
                     out_item.gap_x, out_item.gap_y, out_item.found);
        end
      end
    end
  end

  initial begin
    directed_row_t dir_table [25];
    cfg_t          dir_cfgs [2];
    int            cfg_pick;
    int            random_items;
    int            phase_start;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    gap_cfg   = '0;
    sample_count = 0;
    first_valid  = 0;
    last_valid   = 0;
    seen_valid   = 1'b0;
    prev_x = '0;
    prev_y = '0;
    mismatch_count  = 0;
    results_checked = 0;
    gaps_found      = 0;
    samples_sent    = 0;
    profiles_sent   = 0;
    settings_used   = 0;
    idle_pct        = 0;

    // first rows run on reset settings: no points, last match, zero offsets
    dir_table = '{
      mk(32767, 1, 0, 1, 0, 1, 0, 0, 0),       // single valid sample: nothing to scan
      mk(5, 1, 0, 0, 0),
      mk(7, 1, 1, 0, 0),                       // bad flag ignored before the last sample
      mk(-32768, 0, 0, 1, 0, 1, 0, 5, 1),
      mk(3, 1, 0, 0, 0),
      mk(4, 1, 1, 1, 0, 1, 0, 5, 0),           // bad line repeats the previous position
      mk(1, 0, 0, 0, 0),
      mk(2, 0, 0, 1, 0, 1, 0, 0, 0),           // no valid sample at all
      mk(0, 1, 0, 0, 1),
      mk(3, 1, 0, 0, 0),
      mk(-1, 1, 0, 0, 0),
      mk(2, 1, 0, 0, 0),
      mk(4, 1, 0, 0, 0),
      mk(1, 1, 0, 1, 0),
      mk(10, 0, 0, 0, 0),
      mk(12, 1, 0, 0, 0),
      mk(13, 1, 0, 0, 0),
      mk(32767, 1, 0, 1, 0),
      mk(0, 1, 0, 0, 1),
      mk(-32768, 1, 0, 0, 0),
      mk(5, 1, 0, 0, 0),
      mk(32767, 1, 0, 0, 0),
      mk(9, 0, 0, 1, 0),
      mk(6, 1, 0, 0, 0),
      mk(-7, 1, 0, 1, 0)                       // found with a negative position
    };

    // two points, first match, offsets at both extremes so x saturates
    dir_cfgs[0]           = '0;
    dir_cfgs[0].points[0] = {16'd5, 16'hFFFB, 16'd1};
    dir_cfgs[0].points[1] = {16'hFFF6, 16'd10, 16'hFFFF};
    dir_cfgs[0].points[2] = {16'h7FFF, 16'h8000, 16'h7FFF};
    dir_cfgs[0].mode      = 4'b0101;
    dir_cfgs[0].offsets   = {24'h800000, 24'h7FFFFF};
    // point count above the limit, widest limits, last match
    for (int p = 0; p < PATTERN_POINTS; p++)
      dir_cfgs[1].points[p] = {16'h7FFF, 16'h8000, 16'h0000};
    dir_cfgs[1].mode    = 4'b1110;
    dir_cfgs[1].offsets = {24'hFFFFFF, 24'h800000};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    cfg_pick = 0;
    foreach (dir_table[i]) begin
      if (dir_table[i].reconfig) begin
        drain();
        apply_config(dir_cfgs[cfg_pick]);
        cfg_pick++;
      end
      send_item(dir_table[i].item, dir_table[i].known, dir_table[i].result);
    end
    drain();

    random_items = 0;
    for (int phase = 0; random_items < 700; phase++) begin
      apply_config(random_cfg(phase));
      if (random_items >= 560 || phase % 3 == 2) idle_pct = 0;
      else idle_pct = $urandom_range(0, 1) ? 10 : 30;
      // one overlong profile: samples past the store depth are dropped
      if (phase == 3) send_profile(MAX_SAMPLES + 4, 1'b1);
      phase_start = samples_sent;
      while (samples_sent - phase_start < 70)
        send_profile(($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                 : $urandom_range(1, 16), 1'b0);
      random_items += samples_sent - phase_start;
      drain();
    end

    if (expected_gaps.size() != 0) begin
      $display("%0d expected gap results never arrived", expected_gaps.size());
      mismatch_count += expected_gaps.size();
    end
    $display("Loaded %0d samples in %0d profiles under %0d search settings;",
             samples_sent, profiles_sent, settings_used);
    $display("checked %0d gap results, %0d of them with a pattern match.",
             results_checked, gaps_found);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
